[rtl/wcs_pkg.sv]
// ----------------------------------------------------------------------------
// wcs_pkg
// types and constants shared by the wall column scaler modules
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int TEXTURE_HEIGHT = 128;
    localparam int SCALE_LIMIT    = 2048;
    localparam int FRAC_BITS      = 16;
    localparam int TEX_W          = $clog2(TEXTURE_HEIGHT);
    localparam int NUM_W          = TEX_W + 16;
    localparam int STEP_W         = TEX_W + 16;
    localparam int DIVISOR_W      = 11;
    localparam int DIV_STEPS      = NUM_W;
    localparam int CNT_W          = $clog2(DIV_STEPS);
    localparam int POS_W          = 32;
    localparam int VIEW_W         = 9;
    localparam int ROWS_W         = 10;
    localparam int LOST_W         = 10;
    localparam logic [NUM_W-1:0] DIVIDEND = NUM_W'(TEXTURE_HEIGHT) << 15;
    localparam logic [VIEW_W-1:0] VIEW_RESET = 9'd160;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [9:0] screen_x;
        logic [9:0] scale;
        logic [5:0] tile;
        logic [6:0] texture_column;
    } in_item_t;

    typedef struct packed {
        logic [9:0] out_x;
        logic [8:0] screen_row;
        logic [5:0] out_tile;
        logic [6:0] out_column;
        logic [6:0] texel_row;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic step;
        logic div_step;
        logic mul_load;
    } cmd_t;

    typedef struct packed {
        logic clipped;
        logic run_active;
        logic result_busy;
    } status_t;

endpackage

[rtl/wcs_ctrl.sv]
// ----------------------------------------------------------------------------
// wcs_ctrl
// sequencer for column setup: reciprocal division, clip offset, row steps
// ----------------------------------------------------------------------------
module wcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_kind,
    input  logic             item_zero,
    input  wcs_pkg::status_t status,
    output logic             item_stall,
    output wcs_pkg::cmd_t    cmd
);
    import wcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               accept;

    assign item_stall = (state_reg != ST_IDLE) || status.result_busy;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        cmd.start    = accept && (item_kind == KIND_START);
        cmd.step     = accept && (item_kind == KIND_STEP) && status.run_active;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.mul_load = (state_reg == ST_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (cmd.start && !item_zero)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= status.clipped ? ST_MUL : ST_IDLE;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/wcs_datapath.sv]
// ----------------------------------------------------------------------------
// wcs_datapath
// column setup registers, bit-serial step divider, position accumulator
// and result register
// ----------------------------------------------------------------------------
module wcs_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wcs_pkg::in_item_t        item,
    input  logic                     cfg_write,
    input  logic [8:0]               cfg_data,
    input  wcs_pkg::cmd_t            cmd,
    input  logic                     result_stall,
    output wcs_pkg::status_t         status,
    output logic                     result_valid,
    output wcs_pkg::out_item_t       result
);
    import wcs_pkg::*;

    logic [VIEW_W-1:0]      view_reg;
    logic [POS_W-1:0]       position_reg;
    logic [VIEW_W-1:0]      row_reg;
    logic [ROWS_W-1:0]      rows_left_reg;
    logic [9:0]             x_reg;
    logic [5:0]             tile_reg;
    logic [6:0]             column_reg;
    logic                   clipped_reg;
    logic [LOST_W-1:0]      lost_reg;
    logic [DIVISOR_W-1:0]   divisor_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [NUM_W-1:0]       quot_reg;
    logic                   result_valid_reg;
    out_item_t              result_reg;

    logic [DIVISOR_W-1:0]   drawn;
    logic [DIVISOR_W-1:0]   divisor_start;
    logic                   centred;
    logic [DIVISOR_W:0]     trial;
    logic                   trial_fits;
    logic [STEP_W-1:0]      step_size;
    logic [DIVISOR_W-1:0]   centre_gap;
    logic [DIVISOR_W-1:0]   clip_gap;
    logic [LOST_W+STEP_W-1:0] clip_product;

    assign drawn         = {item.scale, 1'b0};
    assign divisor_start = ({1'b0, drawn} >= (DIVISOR_W+1)'(SCALE_LIMIT))
                         ? DIVISOR_W'(SCALE_LIMIT - 1) : drawn;
    assign centred       = drawn < DIVISOR_W'(view_reg);
    assign centre_gap    = DIVISOR_W'(view_reg) - drawn;
    assign clip_gap      = drawn - DIVISOR_W'(view_reg);
    assign trial         = {rem_reg, num_reg[NUM_W-1]};
    assign trial_fits    = trial >= {1'b0, divisor_reg};
    assign step_size     = {quot_reg[STEP_W-2:0], 1'b0};
    assign clip_product  = (LOST_W+STEP_W)'(lost_reg) * (LOST_W+STEP_W)'(step_size);

    assign status.clipped     = clipped_reg;
    assign status.run_active  = (rows_left_reg != '0);
    assign status.result_busy = result_valid_reg && result_stall;
    assign result_valid       = result_valid_reg;
    assign result             = result_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg         <= VIEW_RESET;
            rows_left_reg    <= '0;
            clipped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                view_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                clipped_reg <= !centred;
                if (item.scale == '0)
                begin
                    rows_left_reg <= '0;
                end
                else if (centred)
                begin
                    rows_left_reg <= drawn[ROWS_W-1:0];
                end
                else
                begin
                    rows_left_reg <= {1'b0, view_reg};
                end
            end
            else if (cmd.step)
            begin
                rows_left_reg <= rows_left_reg - 1'b1;
            end
            if (cmd.step)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg       <= item.screen_x;
            tile_reg    <= item.tile;
            column_reg  <= item.texture_column;
            position_reg <= '0;
            lost_reg    <= clip_gap[DIVISOR_W-1:1];
            divisor_reg <= divisor_start;
            num_reg     <= DIVIDEND;
            rem_reg     <= '0;
            if (item.scale == '0 || !centred)
            begin
                row_reg <= '0;
            end
            else
            begin
                row_reg <= centre_gap[VIEW_W:1];
            end
        end
        else if (cmd.step)
        begin
            position_reg <= position_reg + POS_W'(step_size);
            row_reg      <= row_reg + 1'b1;
        end
        else if (cmd.mul_load)
        begin
            position_reg <= clip_product[POS_W-1:0];
        end

        if (cmd.div_step)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[NUM_W-2:0], trial_fits};
            if (trial_fits)
            begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
        end

        if (cmd.step)
        begin
            result_reg.out_x      <= x_reg;
            result_reg.screen_row <= row_reg;
            result_reg.out_tile   <= tile_reg;
            result_reg.out_column <= column_reg;
            result_reg.texel_row  <= position_reg[FRAC_BITS +: TEX_W];
            result_reg.last       <= (rows_left_reg == ROWS_W'(1));
        end
    end

endmodule

[rtl/wall_column_scaler.sv]
// ----------------------------------------------------------------------------
// wall_column_scaler
// row mapping for one vertically scaled wall texture column
//
//   channel   signals                          direction
//   item      item_valid, item_stall, item     in
//   result    result_valid, result_stall, result  out
//   config    cfg_valid, cfg_ready, cfg_data   in (view height)
//
// row steps flow at one per cycle while the result side drains and no
// setup runs; a column start with nonzero scale runs the bit-serial step
// divider, followed by the offset multiply when the column is clipped
// reset is asynchronous active low; view height resets to 160
// the result register holds while result_stall is high, and item_stall
// rises while setup runs or the held result is stalled
// ----------------------------------------------------------------------------
module wall_column_scaler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  wcs_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output wcs_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import wcs_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    item_zero;

    assign cfg_ready = 1'b1;
    assign item_zero = (item.scale == '0);

    wcs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_zero  (item_zero),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    wcs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
